>>> rtl/itp_pkg.sv
// Shared constants and helper functions for the integer text parser.
`timescale 1ns / 1ps

package itp_pkg;

	localparam int POS_BITS = 16;
	localparam int VALUE_W  = 64;
	localparam int ENDPOS_W = 16;
	localparam int BASE_W   = 5;
	localparam int CHAR_W   = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'd1;

	localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
	localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
	localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
	localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_F   = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_F   = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LO_X   = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_VT     = 8'h0B;
	localparam logic [CHAR_W-1:0] CH_FF     = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

	// marks a character that is not a digit of the current base
	localparam logic [BASE_W-1:0] DIGIT_NONE = 5'd31;

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
		       (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
	endfunction

	function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c,
	                                               input logic [BASE_W-1:0] base);
		logic [BASE_W-1:0] d;
		d = DIGIT_NONE;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = BASE_W'(c - CH_ZERO);
		end else if (base == BASE_HEX && c >= CH_LO_A && c <= CH_LO_F) begin
			d = BASE_W'(c - CH_LO_A) + 5'd10;
		end else if (base == BASE_HEX && c >= CH_UP_A && c <= CH_UP_F) begin
			d = BASE_W'(c - CH_UP_A) + 5'd10;
		end
		if (d >= base) begin
			d = DIGIT_NONE;
		end
		return d;
	endfunction

endpackage

>>> rtl/integer_text_parser_core.sv
// Streaming integer parser: one character per transfer, one result per string.
// Path: a stopping character is registered in the input stage, then its result in the output register.
// Throughput: one character per cycle while char_stall is low; the multiply-add step is combinational.
// Reset: asynchronous, active low; clears parse state, configuration and both valid flags.
// After reset the parser behaves as if a new string had just started.
`timescale 1ns / 1ps

module integer_text_parser_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          char_valid,
	output logic                          char_stall,
	input  logic [itp_pkg::CHAR_W-1:0]    character,
	input  logic                          start_req,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [itp_pkg::VALUE_W-1:0]   value,
	output logic [itp_pkg::ENDPOS_W-1:0]  end_position,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [itp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [itp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import itp_pkg::*;

	typedef enum logic [2:0] {
		PH_WS1    = 3'd0,
		PH_WS2    = 3'd1,
		PH_PREFIX = 3'd2,
		PH_DIGITS = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	localparam int EXT_W = (POS_BITS > ENDPOS_W) ? POS_BITS : ENDPOS_W;
	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	logic [BASE_W-1:0]   number_base_q;
	logic                signed_mode_q;

	phase_t              phase_q;
	logic [VALUE_W-1:0]  acc_q;
	logic [BASE_W-1:0]   base_q;
	logic                neg_q;
	logic [POS_BITS-1:0] pos_q;

	logic                valid_s1;
	logic [CHAR_W-1:0]   char_s1;
	logic                start_s1;

	logic                out_valid_q;
	logic [VALUE_W-1:0]  value_q;
	logic [ENDPOS_W-1:0] endpos_q;

	logic advance;
	logic load_s1;

	phase_t              ph;
	logic [VALUE_W-1:0]  acc;
	logic [BASE_W-1:0]   base;
	logic                neg;
	logic [POS_BITS-1:0] pos;
	logic                bump;
	logic                held;
	logic                emit;
	logic [BASE_W-1:0]   dig;
	logic [VALUE_W-1:0]  prod;
	logic [POS_BITS-1:0] pos_nxt;
	logic [EXT_W-1:0]    pos_ext;
	logic [ENDPOS_W-1:0] endpos_nxt;
	logic [VALUE_W-1:0]  value_nxt;

	assign advance    = !out_valid_q || !result_stall;
	assign load_s1    = !valid_s1 || advance;
	assign char_stall = !load_s1;
	assign cfg_ready  = 1'b1;

	assign result_valid = out_valid_q;
	assign value        = value_q;
	assign end_position = endpos_q;

	always_comb begin
		ph   = start_s1 ? PH_WS1 : phase_q;
		acc  = start_s1 ? '0 : acc_q;
		base = start_s1 ? '0 : base_q;
		neg  = start_s1 ? 1'b0 : neg_q;
		pos  = start_s1 ? '0 : pos_q;
		bump = 1'b0;
		held = 1'b0;
		emit = 1'b0;
		dig  = DIGIT_NONE;
		prod = '0;

		if (ph == PH_WS1) begin
			if (is_space(char_s1)) begin
				bump = 1'b1;
				held = 1'b1;
			end else if (signed_mode_q && (char_s1 == CH_MINUS || char_s1 == CH_PLUS)) begin
				neg  = (char_s1 == CH_MINUS);
				bump = 1'b1;
				held = 1'b1;
				ph   = PH_WS2;
			end else begin
				ph = PH_WS2;
			end
		end

		if (!held && ph == PH_WS2) begin
			if (is_space(char_s1)) begin
				bump = 1'b1;
				held = 1'b1;
			end else if (number_base_q != BASE_AUTO) begin
				base = number_base_q;
				ph   = PH_DIGITS;
			end else if (char_s1 == CH_ZERO) begin
				bump = 1'b1;
				held = 1'b1;
				ph   = PH_PREFIX;
			end else begin
				base = BASE_DEC;
				ph   = PH_DIGITS;
			end
		end

		if (!held && ph == PH_PREFIX) begin
			if (char_s1 == CH_LO_X || char_s1 == CH_UP_X) begin
				base = BASE_HEX;
				bump = 1'b1;
				held = 1'b1;
				ph   = PH_DIGITS;
			end else begin
				base = BASE_OCT;
				ph   = PH_DIGITS;
			end
		end

		if (!held && ph == PH_DIGITS) begin
			dig = digit_of(char_s1, base);
			if (dig != DIGIT_NONE) begin
				// radix is only BASE_W bits wide: shift-and-add multiply
				for (int i = 0; i < BASE_W; i++) begin
					if (base[i]) begin
						prod = prod + (acc << i);
					end
				end
				acc  = prod + VALUE_W'(dig);
				bump = 1'b1;
			end else begin
				emit = 1'b1;
				ph   = PH_DONE;
			end
		end

		pos_nxt    = (bump && pos != POS_MAX) ? pos + 1'b1 : pos;
		pos_ext    = EXT_W'(pos);
		endpos_nxt = (pos_ext > EXT_W'({ENDPOS_W{1'b1}})) ? '1 : pos_ext[ENDPOS_W-1:0];
		value_nxt  = neg ? (~acc + 1'b1) : acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= BASE_AUTO;
			signed_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_NUMBER_BASE: number_base_q <= cfg_data;
				REG_SIGNED_MODE: signed_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WS1;
			acc_q   <= '0;
			base_q  <= '0;
			neg_q   <= 1'b0;
			pos_q   <= '0;
		end else if (valid_s1 && advance) begin
			phase_q <= ph;
			acc_q   <= acc;
			base_q  <= base;
			neg_q   <= neg;
			pos_q   <= pos_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && char_valid) begin
			char_s1  <= character;
			start_s1 <= start_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			value_q  <= value_nxt;
			endpos_q <= endpos_nxt;
		end
	end

endmodule

>>> test/integer_text_parser_core_tb.sv
// Self-checking testbench for integer_text_parser_core: directed strings, random strings, scoreboard.
`timescale 1ns / 1ps

module integer_text_parser_core_tb;
	import itp_pkg::*;

	typedef enum logic [2:0] {
		SCAN_LEAD_WS,
		SCAN_SIGN_WS,
		SCAN_PREFIX,
		SCAN_DIGITS,
		SCAN_DONE
	} scan_phase_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [ENDPOS_W-1:0] end_pos;
	} parse_result_t;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int PHASE_CHARS   = 170;
	localparam int LONG_RUN      = 40;
	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;

	class parse_scoreboard_t;
		logic [BASE_W-1:0]   cfg_base;
		logic                cfg_signed;
		scan_phase_t         ph;
		logic [VALUE_W-1:0]  acc;
		logic [BASE_W-1:0]   radix;
		logic                neg;
		logic [POS_BITS-1:0] pos;
		parse_result_t       expected_q[$];
		int                  mismatches;
		int                  checked;

		function new();
			cfg_base   = BASE_AUTO;
			cfg_signed = 1'b0;
			mismatches = 0;
			checked    = 0;
			restart();
		endfunction

		function void restart();
			ph    = SCAN_LEAD_WS;
			acc   = '0;
			radix = '0;
			neg   = 1'b0;
			pos   = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_NUMBER_BASE) begin
				cfg_base = data[BASE_W-1:0];
			end else begin
				cfg_signed = data[0];
			end
		endfunction

		function bit blank(logic [CHAR_W-1:0] c);
			return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
			       (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
		endfunction

		function int digit_value(logic [CHAR_W-1:0] c);
			int d;
			d = -1;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = int'(c) - int'(CH_ZERO);
			end else if (radix == BASE_HEX && c >= CH_LO_A && c <= CH_LO_F) begin
				d = int'(c) - int'(CH_LO_A) + 10;
			end else if (radix == BASE_HEX && c >= CH_UP_A && c <= CH_UP_F) begin
				d = int'(c) - int'(CH_UP_A) + 10;
			end
			if (d >= int'(radix)) begin
				d = -1;
			end
			return d;
		endfunction

		function void bump();
			if (pos != {POS_BITS{1'b1}}) begin
				pos = pos + 1'b1;
			end
		endfunction

		// advance the parse by one transferred character
		function void note_char(logic [CHAR_W-1:0] c, logic s);
			int            d;
			parse_result_t res;
			if (s) begin
				restart();
			end
			if (ph == SCAN_LEAD_WS) begin
				if (blank(c)) begin
					bump();
					return;
				end
				if (cfg_signed && (c == CH_MINUS || c == CH_PLUS)) begin
					neg = (c == CH_MINUS);
					bump();
					ph = SCAN_SIGN_WS;
					return;
				end
				ph = SCAN_SIGN_WS;
			end
			if (ph == SCAN_SIGN_WS) begin
				if (blank(c)) begin
					bump();
					return;
				end
				if (cfg_base != BASE_AUTO) begin
					radix = cfg_base;
					ph = SCAN_DIGITS;
				end else if (c == CH_ZERO) begin
					bump();
					ph = SCAN_PREFIX;
					return;
				end else begin
					radix = BASE_DEC;
					ph = SCAN_DIGITS;
				end
			end
			if (ph == SCAN_PREFIX) begin
				if (c == CH_LO_X || c == CH_UP_X) begin
					radix = BASE_HEX;
					bump();
					ph = SCAN_DIGITS;
					return;
				end
				radix = BASE_OCT;
				ph = SCAN_DIGITS;
			end
			if (ph == SCAN_DIGITS) begin
				d = digit_value(c);
				if (d >= 0) begin
					acc = acc * VALUE_W'(radix) + VALUE_W'(d);
					bump();
					return;
				end
				res.value   = neg ? (VALUE_W'(0) - acc) : acc;
				res.end_pos = ENDPOS_W'(pos);
				expected_q.push_back(res);
				ph = SCAN_DONE;
			end
		endfunction

		function void check_result(logic [VALUE_W-1:0] v, logic [ENDPOS_W-1:0] p);
			parse_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: value=%h end_position=%0d", v, p);
				end
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (v !== want.value || p !== want.end_pos) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d: expected value=%h end_position=%0d, got value=%h end_position=%0d",
						checked, want.value, want.end_pos, v, p);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  char_valid;
	logic                  char_stall;
	logic [CHAR_W-1:0]     character;
	logic                  start_req;
	logic                  result_valid;
	logic                  result_stall;
	logic [VALUE_W-1:0]    value;
	logic [ENDPOS_W-1:0]   end_position;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	parse_scoreboard_t sb = new();

	bit             idle_on;
	int             cycle_count;
	int             chars_sent;
	int             strings_sent;
	int             cur_base;
	bit             cur_signed;
	logic [CHAR_W-1:0] str_q[$];

	integer_text_parser_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.character    (character),
		.start_req    (start_req),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.end_position (end_position),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				sb.check_result(value, end_position);
			end
			if (char_valid && !char_stall) begin
				sb.note_char(character, start_req);
			end
			if (cfg_valid && cfg_ready) begin
				sb.write_reg(cfg_index, cfg_data);
			end
		end
	end

	// result-side backpressure in random bursts
	initial begin
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 9) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	function automatic logic [CHAR_W-1:0] pick_blank();
		case ($urandom_range(0, 5))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			3: return CH_VT;
			4: return CH_FF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(int b);
		int d;
		d = $urandom_range(0, b - 1);
		if (d < 10) begin
			return CH_ZERO + 8'(d);
		end
		return (($urandom_range(0, 1) == 1) ? CH_LO_A : CH_UP_A) + 8'(d - 10);
	endfunction

	task automatic send_char(logic [CHAR_W-1:0] c, logic s);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		char_valid <= 1'b1;
		character  <= c;
		start_req  <= s;
		do @(posedge clk); while (char_stall);
		chars_sent++;
	endtask

	// let the clock advance first so the last transfer is noted before the check
	task automatic wait_drained();
		char_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 || result_valid) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(int base, bit sgn);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= REG_NUMBER_BASE;
		cfg_data  <= CFG_DATA_W'(base);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_SIGNED_MODE;
		cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, sgn};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		cur_base   = base;
		cur_signed = sgn;
	endtask

	// blanks, optional sign, optional prefix, digits, terminator, trailing junk
	task automatic build_number_text();
		int radix;
		int n;
		str_q.delete();
		repeat ($urandom_range(0, 3)) str_q.push_back(pick_blank());
		if ($urandom_range(0, 3) != 0 && (cur_signed || $urandom_range(0, 7) == 0)) begin
			str_q.push_back(($urandom_range(0, 1) == 1) ? CH_MINUS : CH_PLUS);
			if (cur_signed) begin
				repeat ($urandom_range(0, 2)) str_q.push_back(pick_blank());
			end
		end
		radix = cur_base;
		if (cur_base == 0) begin
			case ($urandom_range(0, 3))
				0: begin
					str_q.push_back(CH_ZERO);
					str_q.push_back(($urandom_range(0, 1) == 1) ? CH_LO_X : CH_UP_X);
					radix = 16;
				end
				1: begin
					str_q.push_back(CH_ZERO);
					radix = 8;
				end
				default: radix = 10;
			endcase
		end else if ($urandom_range(0, 7) == 0) begin
			str_q.push_back(CH_ZERO);
			str_q.push_back(CH_LO_X);
		end
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 30) : $urandom_range(0, 12);
		repeat (n) str_q.push_back(digit_char(radix));
		str_q.push_back(($urandom_range(0, 1) == 1) ? CH_NUL : 8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 3)) str_q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic send_number_text();
		logic first_start;
		build_number_text();
		first_start = ($urandom_range(0, 15) != 0);
		foreach (str_q[i]) begin
			send_char(str_q[i], (i == 0) ? first_start : 1'b0);
		end
		strings_sent++;
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 8)) begin
			send_char(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
		end
		strings_sent++;
	endtask

	task automatic run_random(int base, bit sgn, int n_chars);
		int stop_at;
		set_config(base, sgn);
		stop_at = chars_sent + n_chars;
		while (chars_sent < stop_at) begin
			idle_on = ($urandom_range(0, 5) != 0);
			if ($urandom_range(0, 4) == 0) begin
				send_noise();
			end else begin
				send_number_text();
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		char_valid  = 1'b0;
		character   = '0;
		start_req   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		idle_on     = 1'b1;
		cycle_count = 0;
		chars_sent  = 0;
		strings_sent = 0;
		cur_base    = 0;
		cur_signed  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: no start_req needed, stop on 0xFF
		send_char(CH_SPACE, 1'b0);
		send_char(CH_NINE, 1'b0);
		send_char(8'hFF, 1'b0);
		// uppercase hex prefix
		send_char(CH_ZERO, 1'b1);
		send_char(CH_UP_X, 1'b0);
		send_char(CH_LO_F, 1'b0);
		send_char(CH_NUL, 1'b0);
		// lone hex prefix
		send_char(CH_ZERO, 1'b1);
		send_char(CH_LO_X, 1'b0);
		send_char(CH_NUL, 1'b0);
		// lone zero, octal stops on 9
		send_char(CH_ZERO, 1'b1);
		send_char(CH_NINE, 1'b0);
		// sign in unsigned mode: no digits, trailing char ignored
		send_char(CH_MINUS, 1'b1);
		send_char(CH_ZERO + 8'd5, 1'b0);

		set_config(0, 1'b1);
		send_char(CH_TAB, 1'b1);
		send_char(CH_MINUS, 1'b0);
		send_char(CH_VT, 1'b0);
		send_char(CH_ZERO + 8'd1, 1'b0);
		send_char(CH_NUL, 1'b0);
		send_char(CH_PLUS, 1'b1);
		send_char(CH_PLUS, 1'b0);
		send_char(CH_LF, 1'b1);
		send_char(CH_CR, 1'b0);
		send_char(CH_FF, 1'b0);
		send_char(CH_NUL, 1'b0);
		strings_sent += 8;

		run_random(1, 1'b0, PHASE_CHARS);
		run_random(16, 1'b1, PHASE_CHARS);
		run_random(8, 1'b0, PHASE_CHARS);
		run_random(0, 1'b1, PHASE_CHARS);
		run_random(10, 1'b1, PHASE_CHARS);
		run_random(16, 1'b0, PHASE_CHARS);
		run_random($urandom_range(0, 16), 1'(($urandom_range(0, 1))), PHASE_CHARS);
		run_random($urandom_range(0, 16), 1'(($urandom_range(0, 1))), PHASE_CHARS);

		// no idling from here: a long whitespace run, then a few plain strings
		idle_on = 1'b0;
		set_config(10, 1'b0);
		send_char(CH_SPACE, 1'b1);
		repeat (LONG_RUN) send_char(pick_blank(), 1'b0);
		send_char(CH_ZERO + 8'd1, 1'b0);
		send_char(CH_ZERO + 8'd2, 1'b0);
		send_char(CH_ZERO + 8'd3, 1'b0);
		send_char(CH_NUL, 1'b0);
		strings_sent++;
		repeat (10) send_number_text();

		wait_drained();
		$display("%0d results checked from %0d characters in %0d strings, %0d mismatches",
			sb.checked, chars_sent, strings_sent, sb.mismatches);
		$display("bases auto, 1, 8, 10, 16 and random, signed and unsigned, long whitespace run");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
